// ===== sv/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  // Reciprocal of ten: q = (x * RECIP) >> RECIP_SHIFT is exact for 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // One converted number: sign, digit count and digits, least significant
  // digit in entry zero.
  typedef struct packed {
    logic                                neg;
    logic [CNT_W-1:0]                    ndig;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits;
  } sitda_num_t;

  // ASCII code of a decimal digit.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
  endfunction

endpackage

// ===== sv/sitda_if.sv =====
// ----------------------------------------------------------------------------
// sitda channel interfaces
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sitda_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sitda_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic                          valid;
  logic                          ready;
  logic [sitda_pkg::CHAR_W-1:0]  character;
  logic                          last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Flow: the front takes a number while idle, peels off its decimal digits in
//   turn by multiplying by the reciprocal of ten, then queues them;
//   the registered output stage then sends the text, one character per cycle
//   while out_ch.ready allows. The front takes no new number until it has
//   pushed the last one; the queue lets it convert while the back emits.
// Reset: synchronous active-low rst_n empties the queue and resets the FSMs.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output transaction, with a flag on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  sitda_in_if.sink     in_ch,
  sitda_out_if.source  out_ch
);

  logic                  push_valid;
  logic                  push_ready;
  sitda_pkg::sitda_num_t push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  sitda_pkg::sitda_num_t pop_data;

  // Sign, magnitude and digit extraction
  sitda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue of converted numbers
  sitda_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Character emitter
  sitda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== sv/sitda_front.sv =====
// ----------------------------------------------------------------------------
// sitda_front
// Accepts an integer, forms its magnitude and peels off one decimal digit a
// cycle by reciprocal multiplication and pushes them when the queue has room.
// ----------------------------------------------------------------------------
module sitda_front (
  input  logic                  clk,
  input  logic                  rst_n,
  sitda_in_if.sink              in_ch,
  output logic                  push_valid,
  input  logic                  push_ready,
  output sitda_pkg::sitda_num_t push_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                                                   state_r, state_nxt;
  logic                                                   neg_r, neg_nxt;
  logic [sitda_pkg::VALUE_W-1:0]                          mag_r, mag_nxt;
  logic [sitda_pkg::CNT_W-1:0]                            cnt_r, cnt_nxt;
  logic [sitda_pkg::MAX_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] digits_r, digits_nxt;

  logic [2*sitda_pkg::VALUE_W-1:0]                        prod;
  logic [sitda_pkg::VALUE_W-1:0]                          quot;
  logic [sitda_pkg::VALUE_W-1:0]                          quot10;
  logic [sitda_pkg::VALUE_W-1:0]                          rem;
  logic [sitda_pkg::MAX_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] digits_cur;
  logic [sitda_pkg::VALUE_W-1:0]                          in_raw;
  logic                                                   final_step;
  logic                                                   advance;
  logic                                                   accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_raw      = in_ch.value;

  // Divide the magnitude by ten and keep the remainder as the next digit
  always_comb begin
    prod       = {{sitda_pkg::VALUE_W{1'b0}}, mag_r} *
                 {{sitda_pkg::VALUE_W{1'b0}}, sitda_pkg::RECIP};
    quot       = sitda_pkg::VALUE_W'(prod >> sitda_pkg::RECIP_SHIFT);
    quot10     = (quot << 3) + (quot << 1);
    rem        = mag_r - quot10;
    final_step = (quot == '0);
    digits_cur = digits_r;
    digits_cur[cnt_r] = rem[sitda_pkg::DIGIT_W-1:0];
    advance    = (state_r == ST_DIV) && (!final_step || push_ready);
  end

  // Hand the finished digit set to the queue
  assign push_valid       = (state_r == ST_DIV) && final_step;
  assign push_data.neg    = neg_r;
  assign push_data.ndig   = cnt_r + sitda_pkg::CNT_W'(1);
  assign push_data.digits = digits_cur;

  // Next state: load on accept, advance one digit per cycle unless stalled
  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    cnt_nxt    = cnt_r;
    digits_nxt = digits_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
          neg_nxt   = in_raw[sitda_pkg::VALUE_W-1];
          mag_nxt   = in_raw[sitda_pkg::VALUE_W-1] ? (~in_raw + 32'd1) : in_raw;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        if (advance) begin
          digits_nxt = digits_cur;
          mag_nxt    = quot;
          cnt_nxt    = cnt_r + sitda_pkg::CNT_W'(1);
          if (final_step) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    cnt_r    <= cnt_nxt;
    digits_r <= digits_nxt;
  end

  // A 32-bit magnitude never needs more than ten digits
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < sitda_pkg::CNT_W'(sitda_pkg::MAX_DIGITS)))
    else $error("front digit counter out of range");

  // A blocked final push keeps the division state
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> ((state_r == ST_DIV) && $stable(cnt_r)))
    else $error("front lost state while push stalled");

endmodule

// ===== sv/sitda_fifo.sv =====
// ----------------------------------------------------------------------------
// sitda_fifo
// Short register queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module sitda_fifo #(
  parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  sitda_pkg::sitda_num_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output sitda_pkg::sitda_num_t pop_data
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  sitda_pkg::sitda_num_t   mem_r [DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic                    push;
  logic                    pop;

  assign push_ready = (count_r != COUNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Fill level tracks pointer distance and never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= COUNT_W'(DEPTH)) &&
    ((count_r == '0 || count_r == COUNT_W'(DEPTH)) == (wr_ptr_r == rd_ptr_r)))
    else $error("queue fill level inconsistent with pointers");

endmodule

// ===== sv/sitda_back.sv =====
// ----------------------------------------------------------------------------
// sitda_back
// Takes numbers from the queue and sends their text one character a cycle,
// unless stalled, from an output register, most significant digit first.
// ----------------------------------------------------------------------------
module sitda_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  sitda_pkg::sitda_num_t pop_data,
  sitda_out_if.source           out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                                                   state_r, state_nxt;
  logic                                                   neg_pend_r, neg_pend_nxt;
  logic [sitda_pkg::CNT_W-1:0]                            idx_r, idx_nxt;
  logic [sitda_pkg::MAX_DIGITS-1:0][sitda_pkg::DIGIT_W-1:0] digits_r, digits_nxt;
  logic                                                   out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]                           out_char_r, out_char_nxt;
  logic                                                   out_last_r, out_last_nxt;

  logic                                                   slot_free;
  logic                                                   emit;
  logic                                                   emit_final;

  assign slot_free  = !out_valid_r || out_ch.ready;
  assign emit       = (state_r == ST_EMIT) && slot_free;
  assign emit_final = emit && !neg_pend_r && (idx_r == '0);
  assign pop_ready  = (state_r == ST_IDLE) || emit_final;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last_char = out_last_r;

  // Emit the sign, then digits from the top; load the next number on the last
  always_comb begin
    state_nxt     = state_r;
    neg_pend_nxt  = neg_pend_r;
    idx_nxt       = idx_r;
    digits_nxt    = digits_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: ;
      ST_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          if (neg_pend_r) begin
            out_char_nxt = sitda_pkg::ASCII_MINUS;
            out_last_nxt = 1'b0;
            neg_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = sitda_pkg::digit_char(digits_r[idx_r]);
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - sitda_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (pop_valid && pop_ready) begin
      state_nxt    = ST_EMIT;
      neg_pend_nxt = pop_data.neg;
      idx_nxt      = pop_data.ndig - sitda_pkg::CNT_W'(1);
      digits_nxt   = pop_data.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_pend_r <= neg_pend_nxt;
    idx_r      <= idx_nxt;
    digits_r   <= digits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // A character that is not the last leaves the emitter busy with its number
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT))
    else $error("non-final character with no number in progress");

  // The sign character never closes a number
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == sitda_pkg::ASCII_MINUS)) |-> !out_last_r)
    else $error("minus sign flagged as last character");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for signed_int_to_decimal_ascii. Signed 32-bit numbers go in over
// the valid/ready input channel. Each number's expected decimal text is worked
// out here, one character per entry, and queued. Every character that leaves
// the block is compared with the oldest queued entry. Both channels idle in
// random bursts, except in the closing streaming test.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] character;
    logic                         last_char;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n;

  sitda_in_if  in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_char_t  pending_chars[$];
  int unsigned numbers_sent;
  int unsigned chars_checked;
  int unsigned mismatch_count;
  bit          idle_on;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue the decimal text of one number: sign, then digits, MSD first
  function automatic void push_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] value);
    logic                         neg;
    logic [sitda_pkg::VALUE_W:0]  mag;
    logic [sitda_pkg::CHAR_W-1:0] digit_q[$];
    text_char_t                   tc;
    neg = value[sitda_pkg::VALUE_W-1];
    // 33-bit magnitude so the most negative value survives negation
    mag = neg ? (~{1'b1, value} + 33'd1) : {1'b0, value};
    if (mag == '0) digit_q.push_front(sitda_pkg::ASCII_ZERO);
    while (mag != '0) begin
      digit_q.push_front(sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(mag % 33'd10));
      mag = mag / 33'd10;
    end
    if (neg) begin
      tc.character = sitda_pkg::ASCII_MINUS;
      tc.last_char = 1'b0;
      pending_chars.push_back(tc);
    end
    foreach (digit_q[i]) begin
      tc.character = digit_q[i];
      tc.last_char = (i == digit_q.size() - 1);
      pending_chars.push_back(tc);
    end
  endfunction

  // Power of ten as a 64-bit value
  function automatic longint pow10(input int k);
    longint p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Pick a value: full random, by digit count, small, or near a decade edge or an extreme
  function automatic logic [sitda_pkg::VALUE_W-1:0] random_value();
    logic   neg;
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    neg = 1'($urandom_range(1));
    mag = 0;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        nd  = $urandom_range(10, 1);
        lo  = (nd == 1) ? 0 : pow10(nd - 1);
        hi  = pow10(nd) - 1;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = lo + longint'($urandom_range(int'(hi - lo)));
      end
      2: mag = longint'($urandom_range(99));
      default: begin
        if ($urandom_range(4) == 0) begin
          mag = neg ? 64'd2147483648 - longint'($urandom_range(1)) : 64'd2147483647;
        end else begin
          mag = pow10(int'($urandom_range(9))) + longint'($urandom_range(2)) - 1;
        end
      end
    endcase
    return neg ? sitda_pkg::VALUE_W'(-mag) : sitda_pkg::VALUE_W'(mag);
  endfunction

  // Send one number; optionally idle first, then hold until accepted
  task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] value);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(18, 1);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    push_decimal_text(value);
    numbers_sent++;
  endtask

  // Record one failure; print only the first few
  function automatic void note_mismatch(input string what,
                                        input logic [sitda_pkg::CHAR_W-1:0] exp_v,
                                        input logic [sitda_pkg::CHAR_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected %02h, got %02h", $time, what, exp_v, act_v);
  endfunction

  // Check each output transaction against the oldest expected character
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch("unexpected character", '0, out_ch.character);
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_ch.character !== exp_c.character)
          note_mismatch("character", exp_c.character, out_ch.character);
        if (out_ch.last_char !== exp_c.last_char)
          note_mismatch("last_char", sitda_pkg::CHAR_W'(exp_c.last_char),
                        sitda_pkg::CHAR_W'(out_ch.last_char));
        chars_checked++;
      end
    end
  end

  // Drive out_ch.ready in random run and stall bursts
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(2) == 0) begin
        n = $urandom_range(18, 1);
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end else begin
        n = $urandom_range(24, 1);
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  // Extremes, zero, single digits, decade edges and bit patterns
  task automatic test_directed_values();
    logic [sitda_pkg::VALUE_W-1:0] values[$];
    values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
               -32'sd1000000000, 32'd999999999, -32'sd999999999, 32'h5555_5555,
               32'hAAAA_AAAA, 32'd123456789, -32'sd123456789, 32'd2147483640};
    foreach (values[i]) send_value(values[i]);
  endtask

  // Random mix of values with idling on both channels
  task automatic test_random_values(input int count);
    idle_on = 1'b1;
    repeat (count) send_value(random_value());
  endtask

  // Back-to-back numbers with no input gaps and the output always ready
  task automatic test_streaming(input int count);
    idle_on = 1'b0;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    rst_n          = 1'b0;
    idle_on        = 1'b1;
    numbers_sent   = 0;
    chars_checked  = 0;
    mismatch_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_values();
    test_random_values(200);
    test_streaming(80);

    // Drop valid and drain the output
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Converted %0d numbers, %0d characters checked, %0d mismatches.",
             numbers_sent, chars_checked, mismatch_count);
    $display("Covered zero, both 32-bit extremes, every digit count and random stalls.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sitda_pkg.sv
sv/sitda_if.sv
sv/sitda_front.sv
sv/sitda_fifo.sv
sv/sitda_back.sv
sv/signed_int_to_decimal_ascii.sv
dv/tb.sv
